>>> design/rpi_pkg.sv
// ----------------------------------------------------------------------------
// rpi_pkg: shared types and constants for the ray/plane intersection pipeline
// Payload structs, register indexes, status codes and pipeline constants.
// ----------------------------------------------------------------------------
package rpi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    // quotient bits of the per-axis step; the step magnitude clamps to 2^40
    localparam int STEP_QBITS    = 41;
    // cycles from an accepted start to the result strobe
    localparam int LATENCY       = STEP_QBITS + 8;
    localparam logic [31:0] NORMAL_Z_RESET = 32'h0001_0000;

    typedef enum logic [2:0] {
        REG_NORMAL_X  = 3'd0,
        REG_NORMAL_Y  = 3'd1,
        REG_NORMAL_Z  = 3'd2,
        REG_OFFSET    = 3'd3,
        REG_THRESHOLD = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_PARALLEL = 2'd0,
        ST_FRONT    = 2'd1,
        ST_BEHIND   = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_ray_in;

    typedef struct packed {
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic [1:0]         hit_status;
    } t_hit_out;

    // per-ray control and origin carried alongside the dividers
    typedef struct packed {
        logic             par;
        logic             tneg;
        logic [2:0]       neg;
        logic [2:0][31:0] org;
    } t_side;

endpackage

>>> design/rpi_div.sv
// ----------------------------------------------------------------------------
// rpi_div: pipelined restoring divider with clamp
// One quotient bit per stage; quotients at or above the clamp value return it.
// ----------------------------------------------------------------------------
module rpi_div #(
    parameter int NW = 91,
    parameter int DW = 51,
    parameter int QB = rpi_pkg::STEP_QBITS
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quot
);
    import rpi_pkg::*;

    localparam logic [QB-1:0] CLAMP = QB'(1) << (QB - 1);

    logic [DW-1:0] r_rem [0:QB];
    logic [QB-1:0] r_low [0:QB];
    logic [QB-1:0] r_quo [0:QB];
    logic [DW-1:0] r_den [0:QB];
    logic          r_ovf [0:QB];
    logic [DW-1:0] c_hi;

    // the bits above the quotient range decide overflow up front
    assign c_hi = DW'(i_num[NW-1:QB]);

    always_ff @(posedge i_clk) begin
        r_ovf[0] <= (c_hi >= i_den);
        r_rem[0] <= c_hi;
        r_low[0] <= i_num[QB-1:0];
        r_quo[0] <= '0;
        r_den[0] <= i_den;
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [DW:0] c_trial;
        logic        c_ge;
        assign c_trial = {r_rem[k], r_low[k][QB-1]};
        assign c_ge    = (c_trial >= {1'b0, r_den[k]});
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= c_ge ? DW'(c_trial - {1'b0, r_den[k]}) : DW'(c_trial);
            r_low[k+1] <= r_low[k] << 1;
            r_quo[k+1] <= {r_quo[k][QB-2:0], c_ge};
            r_den[k+1] <= r_den[k];
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    always_ff @(posedge i_clk) begin
        o_quot <= (r_ovf[QB] || (r_quo[QB] > CLAMP)) ? CLAMP : r_quo[QB];
    end

endmodule

>>> design/ray_plane_intersect.sv
// ----------------------------------------------------------------------------
// ray_plane_intersect: fixed-point ray/plane intersection
// Streams rays against a plane held in APB registers; returns the hit point.
// ----------------------------------------------------------------------------
// One ray enters per clock: busy stays low and start is taken in every cycle.
// Each result appears on o_hit with o_done, in the order of the start beats,
// for one cycle; the receiver has to take it then.
// The latency is set by the three per-axis dividers, which resolve one
// quotient bit per pipeline stage, plus eight stages: dot products, numerator,
// partial and full products, divider load and clamp, and final saturation.
// Write registers only while no ray is in flight.
module ray_plane_intersect #(
    parameter int FRAC_BITS = rpi_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rpi_pkg::t_ray_in  i_ray,
    output logic              o_done,
    output rpi_pkg::t_hit_out o_hit,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import rpi_pkg::*;

    localparam int DW = 67 - FRAC_BITS;   // dot products and numerator
    localparam int LW = DW / 2;
    localparam int HW = DW - LW;
    localparam int PW = 32 + DW;          // |dir| * |num|
    localparam int QB = STEP_QBITS;
    localparam int DL = QB + 2;           // divider latency

    // ---------------- registers ----------------
    logic signed [31:0] r_nrm [3];
    logic signed [31:0] r_offset;
    logic [30:0]        r_thresh;
    t_reg_idx           c_idx;

    assign c_idx  = t_reg_idx'(paddr[4:2]);
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm[0] <= '0;
            r_nrm[1] <= '0;
            r_nrm[2] <= NORMAL_Z_RESET;
            r_offset <= '0;
            r_thresh <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (c_idx)
                REG_NORMAL_X:  r_nrm[0] <= pwdata;
                REG_NORMAL_Y:  r_nrm[1] <= pwdata;
                REG_NORMAL_Z:  r_nrm[2] <= pwdata;
                REG_OFFSET:    r_offset <= pwdata;
                REG_THRESHOLD: r_thresh <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (c_idx)
            REG_NORMAL_X:  prdata = r_nrm[0];
            REG_NORMAL_Y:  prdata = r_nrm[1];
            REG_NORMAL_Z:  prdata = r_nrm[2];
            REG_OFFSET:    prdata = r_offset;
            REG_THRESHOLD: prdata = {1'b0, r_thresh};
            default:       prdata = '0;
        endcase
    end

    // ---------------- stage 1: six products ----------------
    logic signed [31:0] c_org [3];
    logic signed [31:0] c_dir [3];
    logic               r1_v;
    logic signed [31:0] r1_o  [3];
    logic signed [31:0] r1_d  [3];
    logic signed [63:0] r1_po [3];
    logic signed [63:0] r1_pd [3];

    assign c_org[0] = i_ray.origin_x;
    assign c_org[1] = i_ray.origin_y;
    assign c_org[2] = i_ray.origin_z;
    assign c_dir[0] = i_ray.dir_x;
    assign c_dir[1] = i_ray.dir_y;
    assign c_dir[2] = i_ray.dir_z;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_o[k]  <= c_org[k];
            r1_d[k]  <= c_dir[k];
            r1_po[k] <= 64'(c_org[k]) * 64'(r_nrm[k]);
            r1_pd[k] <= 64'(c_dir[k]) * 64'(r_nrm[k]);
        end
    end

    // ---------------- stage 2: floor and sum ----------------
    logic signed [DW-1:0] c_to [3];
    logic signed [DW-1:0] c_td [3];
    logic                 r2_v;
    logic signed [31:0]   r2_o [3];
    logic signed [31:0]   r2_d [3];
    logic signed [DW-1:0] r2_pn;
    logic signed [DW-1:0] r2_dn;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_to[k] = DW'(r1_po[k] >>> FRAC_BITS);
            c_td[k] = DW'(r1_pd[k] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        r2_o  <= r1_o;
        r2_d  <= r1_d;
        r2_pn <= c_to[0] + c_to[1] + c_to[2];
        r2_dn <= c_td[0] + c_td[1] + c_td[2];
    end

    // ---------------- stage 3: numerator, magnitudes, signs ----------------
    logic signed [DW-1:0] c_num;
    logic [DW-1:0]        c_nmag;
    logic [DW-1:0]        c_dmag;
    logic                 r3_v;
    logic [DW-1:0]        r3_nmag;
    logic [DW-1:0]        r3_dmag;
    logic [31:0]          r3_adv [3];
    t_side                c_sd;
    t_side                r3_sd;

    assign c_num  = DW'(r_offset) - r2_pn;
    assign c_nmag = c_num[DW-1] ? DW'(-c_num) : DW'(c_num);
    assign c_dmag = r2_dn[DW-1] ? DW'(-r2_dn) : DW'(r2_dn);

    always_comb begin
        c_sd.par  = (c_dmag <= DW'(r_thresh));
        c_sd.tneg = (c_num != '0) && (c_num[DW-1] != r2_dn[DW-1]);
        for (int k = 0; k < 3; k++) begin
            c_sd.neg[k] = r2_d[k][31] ^ c_num[DW-1] ^ r2_dn[DW-1];
            c_sd.org[k] = r2_o[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r3_nmag <= c_nmag;
        r3_dmag <= c_dmag;
        r3_sd   <= c_sd;
        for (int k = 0; k < 3; k++) begin
            r3_adv[k] <= r2_d[k][31] ? 32'(-r2_d[k]) : 32'(r2_d[k]);
        end
    end

    // ---------------- stage 4: partial products ----------------
    logic          r4_v;
    logic [31+LW:0] r4_plo [3];
    logic [31+HW:0] r4_phi [3];
    logic [DW-1:0] r4_dmag;
    t_side         r4_sd;

    always_ff @(posedge i_clk) begin
        r4_dmag <= r3_dmag;
        r4_sd   <= r3_sd;
        for (int k = 0; k < 3; k++) begin
            r4_plo[k] <= (32+LW)'(r3_adv[k]) * (32+LW)'(r3_nmag[LW-1:0]);
            r4_phi[k] <= (32+HW)'(r3_adv[k]) * (32+HW)'(r3_nmag[DW-1:LW]);
        end
    end

    // ---------------- stage 5: full product ----------------
    logic          r5_v;
    logic [PW-1:0] r5_p [3];
    logic [DW-1:0] r5_dmag;
    t_side         r5_sd;

    always_ff @(posedge i_clk) begin
        r5_dmag <= r4_dmag;
        r5_sd   <= r4_sd;
        for (int k = 0; k < 3; k++) begin
            r5_p[k] <= (PW'(r4_phi[k]) << LW) + PW'(r4_plo[k]);
        end
    end

    // ---------------- dividers and side delay ----------------
    logic [QB-1:0] c_quot [3];
    t_side         r_sd [0:DL-1];
    logic [DL-1:0] r_sv;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        rpi_div #(
            .NW (PW),
            .DW (DW),
            .QB (QB)
        ) u_div (
            .i_clk  (i_clk),
            .i_num  (r5_p[k]),
            .i_den  (r5_dmag),
            .o_quot (c_quot[k])
        );
    end

    always_ff @(posedge i_clk) begin
        r_sd[0] <= r5_sd;
        for (int k = 1; k < DL; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r_sv <= '0;
        end else begin
            r1_v <= start && !busy;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r_sv <= {r_sv[DL-2:0], r5_v};
        end
    end

    // ---------------- final: apply step, saturate ----------------
    t_side              c_fs;
    logic signed [42:0] c_q   [3];
    logic signed [42:0] c_sum [3];
    logic signed [31:0] c_hit [3];
    t_hit_out           n_hit;

    assign c_fs = r_sd[DL-1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_q[k]   = $signed({2'b00, c_quot[k]});
            c_sum[k] = 43'($signed(c_fs.org[k])) + (c_fs.neg[k] ? -c_q[k] : c_q[k]);
            if (c_sum[k][42:31] == {12{c_sum[k][42]}}) begin
                c_hit[k] = c_sum[k][31:0];
            end else begin
                c_hit[k] = c_sum[k][42] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
        end
        if (c_fs.par) begin
            n_hit.hit_x      = '0;
            n_hit.hit_y      = '0;
            n_hit.hit_z      = '0;
            n_hit.hit_status = ST_PARALLEL;
        end else begin
            n_hit.hit_x      = c_hit[0];
            n_hit.hit_y      = c_hit[1];
            n_hit.hit_z      = c_hit[2];
            n_hit.hit_status = c_fs.tneg ? ST_BEHIND : ST_FRONT;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit <= n_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_sv[DL-1];
        end
    end

endmodule

>>> design/rpi_chk.sv
// ----------------------------------------------------------------------------
// rpi_chk: port-level checks for the ray/plane intersection block
// Watches beats on the start and result ports and the shape of results.
// ----------------------------------------------------------------------------
module rpi_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input rpi_pkg::t_hit_out o_hit
);
    import rpi_pkg::*;

    // every accepted beat yields exactly one result a fixed time later
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("result missing after accepted beat");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !$past(start && !busy, LATENCY)) |-> $past(!i_rst_n, LATENCY))
        else $error("result without accepted beat");

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit.hit_status == ST_PARALLEL) |->
        (o_hit.hit_x == 0 && o_hit.hit_y == 0 && o_hit.hit_z == 0))
        else $error("parallel result carries a point");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hit.hit_status == ST_PARALLEL || o_hit.hit_status == ST_FRONT
                    || o_hit.hit_status == ST_BEHIND))
        else $error("bad status code");

endmodule

bind ray_plane_intersect rpi_chk u_rpi_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_hit   (o_hit)
);

>>> tb/ray_plane_intersect_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_plane_intersect_tb: self-checking bench for the ray/plane intersection
// Streams rays in bursts under several plane settings written over APB. Each
// hit beat is field-checked against a bit-exact predictor or a typed-in hit.
// ----------------------------------------------------------------------------
module ray_plane_intersect_tb;
    import rpi_pkg::*;

    localparam int NUM_RANDOM = 1850;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_ray_in     i_ray;
    logic        o_done;
    t_hit_out    o_hit;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ray_plane_intersect u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_ray   (i_ray),
        .o_done  (o_done),
        .o_hit   (o_hit),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // plane copy held by the predictor
    logic signed [31:0] plane_n [3];
    logic signed [31:0] plane_d;
    logic [30:0]        plane_thr;

    t_hit_out hit_queue [$];
    int mismatches;
    int hits_seen;
    int n_parallel, n_front, n_behind;
    longint cycles;

    function automatic logic signed [63:0] floor_prod(logic signed [31:0] a,
                                                      logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p >>> FRAC_BITS_DEF;
    endfunction

    // |a|*|b|/d truncated, clamped to 2^40
    function automatic logic [63:0] axis_step(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] d);
        logic [127:0] q;
        q = (128'(a) * 128'(b)) / 128'(d);
        if (q > (128'd1 << 40)) return 64'd1 << 40;
        return q[63:0];
    endfunction

    function automatic t_hit_out predict_hit(t_ray_in r);
        t_hit_out h;
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        logic signed [63:0] pn, dn, num, s, sum;
        logic [63:0] dmag, nmag, q;
        logic neg;
        org = '{r.origin_x, r.origin_y, r.origin_z};
        dir = '{r.dir_x, r.dir_y, r.dir_z};
        pn = 0;
        dn = 0;
        for (int k = 0; k < 3; k++) begin
            pn += floor_prod(org[k], plane_n[k]);
            dn += floor_prod(dir[k], plane_n[k]);
        end
        h = '0;
        dmag = dn < 0 ? -dn : dn;
        if (dmag <= 64'(plane_thr)) begin
            h.hit_status = ST_PARALLEL;
            return h;
        end
        num = 64'(plane_d) - pn;
        nmag = num < 0 ? -num : num;
        for (int k = 0; k < 3; k++) begin
            q = axis_step(dir[k] < 0 ? -64'(dir[k]) : 64'(dir[k]), nmag, dmag);
            neg = ((dir[k] < 0) != (num < 0)) != (dn < 0);
            s = neg ? -$signed(q) : $signed(q);
            sum = 64'(org[k]) + s;
            if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
            if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
            if (k == 0) h.hit_x = sum[31:0];
            else if (k == 1) h.hit_y = sum[31:0];
            else h.hit_z = sum[31:0];
        end
        h.hit_status = (num != 0 && ((num < 0) != (dn < 0))) ? ST_BEHIND : ST_FRONT;
        return h;
    endfunction

    // check hit beats as they leave the block
    always @(posedge i_clk) begin
        t_hit_out exp_hit;
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            hits_seen <= hits_seen + 1;
            if (hit_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected hit beat %h", o_hit);
            end else begin
                exp_hit = hit_queue.pop_front();
                if (o_hit.hit_status == ST_PARALLEL) n_parallel++;
                else if (o_hit.hit_status == ST_FRONT) n_front++;
                else n_behind++;
                if (o_hit.hit_x !== exp_hit.hit_x || o_hit.hit_y !== exp_hit.hit_y ||
                    o_hit.hit_z !== exp_hit.hit_z ||
                    o_hit.hit_status !== exp_hit.hit_status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hit mismatch: exp %h %h %h %0d got %h %h %h %0d",
                                 exp_hit.hit_x, exp_hit.hit_y, exp_hit.hit_z,
                                 exp_hit.hit_status, o_hit.hit_x, o_hit.hit_y,
                                 o_hit.hit_z, o_hit.hit_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NORMAL_X:  plane_n[0] = val;
            REG_NORMAL_Y:  plane_n[1] = val;
            REG_NORMAL_Z:  plane_n[2] = val;
            REG_OFFSET:    plane_d = val;
            REG_THRESHOLD: plane_thr = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                             logic [31:0] d, logic [31:0] thr);
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_OFFSET, d);
        write_reg(REG_THRESHOLD, thr);
    endtask

    // send one ray; optionally push a typed-in expectation instead of predicting
    task automatic send_ray(t_ray_in r, bit use_fixed, t_hit_out fixed_hit);
        start <= 1'b1;
        i_ray <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        hit_queue.push_back(use_fixed ? fixed_hit : predict_hit(r));
    endtask

    task automatic drain();
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 8;
            default: return 32'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    typedef struct {
        t_ray_in  ray;
        bit       fixed;
        t_hit_out hit;
    } t_ray_row;

    t_ray_row ray_table [] = '{
        // reset plane z = 0: straight down from z = 5
        '{'{32'h0, 32'h0, 32'h5_0000, 32'h0, 32'h0, 32'hFFFF_0000}, 1,
          '{32'h0, 32'h0, 32'h0, ST_FRONT}},
        // ray behind the origin
        '{'{32'h1_0000, 32'h2_0000, 32'h5_0000, 32'h0, 32'h0, 32'h1_0000}, 1,
          '{32'h1_0000, 32'h2_0000, 32'h0, ST_BEHIND}},
        // parallel ray, direction in the plane
        '{'{32'h3_0000, 32'h4_0000, 32'h5_0000, 32'h1_0000, 32'h0, 32'h0}, 1,
          '{32'h0, 32'h0, 32'h0, ST_PARALLEL}},
        // origin on the plane
        '{'{32'h7_0000, 32'hFFF9_0000, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000}, 1,
          '{32'h7_0000, 32'hFFF9_0000, 32'h0, ST_FRONT}},
        // zero direction is parallel
        '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0}, 1,
          '{32'h0, 32'h0, 32'h0, ST_PARALLEL}},
        // huge t: coordinates saturate
        '{'{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF}, 0,
          '{default: '0}},
        '{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h0000_0001}, 0, '{default: '0}},
        '{'{32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF}, 0, '{default: '0}},
        '{'{32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h8000_0000}, 0, '{default: '0}},
        '{'{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF}, 0, '{default: '0}}
    };

    initial begin
        t_ray_in r;
        int left, gap;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_ray   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        cycles = 0;
        mismatches = 0;
        hits_seen = 0;
        n_parallel = 0;
        n_front = 0;
        n_behind = 0;
        plane_n = '{32'h0, 32'h0, NORMAL_Z_RESET};
        plane_d = 0;
        plane_thr = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (ray_table[i]) send_ray(ray_table[i].ray, ray_table[i].fixed, ray_table[i].hit);
        start <= 1'b0;
        drain();

        // extreme plane: full-scale normal, offset and threshold
        set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
        foreach (ray_table[i]) send_ray(ray_table[i].ray, 0, '0);
        start <= 1'b0;
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_plane(32'h0, 32'h1_0000, 32'h0, 32'h3_0000, 32'h0);
                1: set_plane(32'h93CD, 32'h93CD, 32'h93CD, 32'hFFF6_0000, 32'h100);
                2: set_plane(32'hFFFF_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0);
                3: set_plane($urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom() & 32'h7FFF_FFFF);
                4: set_plane(32'hB505, 32'h0, 32'hFFFF_4AFB, $urandom(),
                             $urandom_range(0, 32'h2_0000));
                default: set_plane(32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0);
            endcase
            left = NUM_RANDOM / 6;
            while (left > 0) begin
                for (int b = $urandom_range(1, 40); b > 0 && left > 0; b--) begin
                    r.origin_x = rand_coord();
                    r.origin_y = rand_coord();
                    r.origin_z = rand_coord();
                    r.dir_x = rand_coord();
                    r.dir_y = rand_coord();
                    r.dir_z = rand_coord();
                    send_ray(r, 0, '0);
                    left--;
                end
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
                // hold start high across a zero gap
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            start <= 1'b0;
            drain();
        end

        $display("checked %0d hit beats over 8 plane settings: %0d parallel, %0d front, %0d behind",
                 hits_seen, n_parallel, n_front, n_behind);
        if (mismatches == 0 && hit_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
